// ===== rtl/core/bmpi_pkg.sv =====
// Shared types and constants for the bus mouse port interface.
`timescale 1ns / 1ps
`default_nettype none

package bmpi_pkg;

  typedef enum logic [2:0] {
    CMD_READ_A  = 3'd0,
    CMD_READ_B  = 3'd1,
    CMD_READ_C  = 3'd2,
    CMD_WRITE_C = 3'd3,
    CMD_BUTTON  = 3'd4,
    CMD_MOTION  = 3'd5,
    CMD_TICK    = 3'd6
  } cmd_t;

  localparam int unsigned NUM_BUTTONS = 3;

  // Port C write bit positions
  localparam int unsigned HOLD_BIT    = 7;
  localparam int unsigned NIB_SEL_LO  = 5;
  localparam int unsigned IRQ_DIS_BIT = 4;

  localparam logic [7:0] PORT_B_VALUE = 8'hFF;

  localparam logic signed [15:0] TAKE_MIN = -16'sd128;
  localparam logic signed [15:0] TAKE_MAX = 16'sd127;
  localparam logic signed [15:0] ACC_MIN  = -16'sd32768;
  localparam logic signed [15:0] ACC_MAX  = 16'sd32767;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         port_value;
    logic [1:0]         button_index;
    logic               button_pressed;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmpi_if.sv =====
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
`default_nettype none

interface bmpi_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         port_value;
  logic [1:0]         button_index;
  logic               button_pressed;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;

  modport source (output valid, cmd, port_value, button_index, button_pressed,
                  move_x, move_y, input ready);
  modport sink   (input valid, cmd, port_value, button_index, button_pressed,
                  move_x, move_y, output ready);
endinterface

interface bmpi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_out;

  modport source (output valid, read_data, irq_out, input ready);
  modport sink   (input valid, read_data, irq_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmpi_core.sv =====
// Mouse state registers and per-item update and read logic.
`timescale 1ns / 1ps
`default_nettype none

module bmpi_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire bmpi_pkg::item_t  item,
  output bmpi_pkg::result_t     result
);

  logic signed [15:0] pending_x_r, pending_x_nxt;
  logic signed [15:0] pending_y_r, pending_y_nxt;
  logic [2:0]         live_buttons_r, live_buttons_nxt;
  logic [7:0]         held_x_r, held_x_nxt;
  logic [7:0]         held_y_r, held_y_nxt;
  logic [2:0]         held_buttons_r, held_buttons_nxt;
  logic               hold_r, hold_nxt;
  logic [1:0]         nib_sel_r, nib_sel_nxt;
  logic               irq_en_r, irq_en_nxt;
  logic               irq_req_r, irq_req_nxt;
  logic               irq_lvl_r, irq_lvl_nxt;

  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic signed [15:0] take_x, take_y;
  logic [3:0]         nib;
  logic [7:0]         rd;

  // 17-bit sums, clamped back to 16 bits
  assign sum_x = {pending_x_r[15], pending_x_r} + {item.move_x[15], item.move_x};
  assign sum_y = {pending_y_r[15], pending_y_r} + {item.move_y[15], item.move_y};

  always_comb begin
    if (sum_x > 17'sd32767)       sat_x = bmpi_pkg::ACC_MAX;
    else if (sum_x < -17'sd32768) sat_x = bmpi_pkg::ACC_MIN;
    else                          sat_x = sum_x[15:0];
    if (sum_y > 17'sd32767)       sat_y = bmpi_pkg::ACC_MAX;
    else if (sum_y < -17'sd32768) sat_y = bmpi_pkg::ACC_MIN;
    else                          sat_y = sum_y[15:0];
  end

  // Portion moved out on a hold edge, limited to one signed byte
  always_comb begin
    if (pending_x_r < bmpi_pkg::TAKE_MIN)      take_x = bmpi_pkg::TAKE_MIN;
    else if (pending_x_r > bmpi_pkg::TAKE_MAX) take_x = bmpi_pkg::TAKE_MAX;
    else                                       take_x = pending_x_r;
    if (pending_y_r < bmpi_pkg::TAKE_MIN)      take_y = bmpi_pkg::TAKE_MIN;
    else if (pending_y_r > bmpi_pkg::TAKE_MAX) take_y = bmpi_pkg::TAKE_MAX;
    else                                       take_y = pending_y_r;
  end

  always_comb begin
    unique case (nib_sel_r)
      2'd0:    nib = held_x_r[3:0];
      2'd1:    nib = held_x_r[7:4];
      2'd2:    nib = held_y_r[3:0];
      default: nib = held_y_r[7:4];
    endcase
  end

  always_comb begin
    pending_x_nxt    = pending_x_r;
    pending_y_nxt    = pending_y_r;
    live_buttons_nxt = live_buttons_r;
    held_x_nxt       = held_x_r;
    held_y_nxt       = held_y_r;
    held_buttons_nxt = held_buttons_r;
    hold_nxt         = hold_r;
    nib_sel_nxt      = nib_sel_r;
    irq_en_nxt       = irq_en_r;
    irq_req_nxt      = irq_req_r;
    irq_lvl_nxt      = irq_lvl_r;
    rd               = 8'h00;
    unique case (item.cmd)
      bmpi_pkg::CMD_READ_A: rd = {~held_buttons_r, 1'b0, nib};
      bmpi_pkg::CMD_READ_B: rd = bmpi_pkg::PORT_B_VALUE;
      bmpi_pkg::CMD_READ_C: rd = {7'd0, irq_req_r & irq_en_r};
      bmpi_pkg::CMD_WRITE_C: begin
        hold_nxt    = item.port_value[bmpi_pkg::HOLD_BIT];
        nib_sel_nxt = item.port_value[bmpi_pkg::NIB_SEL_LO +: 2];
        irq_en_nxt  = ~item.port_value[bmpi_pkg::IRQ_DIS_BIT];
        if (item.port_value[bmpi_pkg::HOLD_BIT] && !hold_r) begin
          held_buttons_nxt = live_buttons_r;
          held_x_nxt       = take_x[7:0];
          held_y_nxt       = take_y[7:0];
          pending_x_nxt    = pending_x_r - take_x;
          pending_y_nxt    = pending_y_r - take_y;
        end
      end
      bmpi_pkg::CMD_BUTTON: begin
        // button index three is ignored
        if (item.button_index < 2'(bmpi_pkg::NUM_BUTTONS)) begin
          live_buttons_nxt[item.button_index] = item.button_pressed;
        end
      end
      bmpi_pkg::CMD_MOTION: begin
        pending_x_nxt = sat_x;
        pending_y_nxt = sat_y;
      end
      bmpi_pkg::CMD_TICK: begin
        irq_req_nxt = ~irq_req_r;
        irq_lvl_nxt = ~irq_req_r & irq_en_r;
      end
      default: ;
    endcase
  end

  assign result.read_data = rd;
  assign result.irq_out   = irq_lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_x_r    <= '0;
      pending_y_r    <= '0;
      live_buttons_r <= '0;
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_buttons_r <= '0;
      hold_r         <= 1'b0;
      nib_sel_r      <= '0;
      irq_en_r       <= 1'b0;
      irq_req_r      <= 1'b0;
      irq_lvl_r      <= 1'b0;
    end else if (fire) begin
      pending_x_r    <= pending_x_nxt;
      pending_y_r    <= pending_y_nxt;
      live_buttons_r <= live_buttons_nxt;
      held_x_r       <= held_x_nxt;
      held_y_r       <= held_y_nxt;
      held_buttons_r <= held_buttons_nxt;
      hold_r         <= hold_nxt;
      nib_sel_r      <= nib_sel_nxt;
      irq_en_r       <= irq_en_nxt;
      irq_req_r      <= irq_req_nxt;
      irq_lvl_r      <= irq_lvl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bus_mouse_port_interface.sv =====
// Top level of the bus mouse port interface: input register, core, result register.
// Bus mouse behind three byte ports. Each item is one port access or one mouse event:
// read A (selected X/Y nibble with inverted held buttons in bits 7:5), read B (0xFF),
// read C (interrupt status in bit 0), write C (hold in bit 7, nibble select in bits
// 6:5, interrupt disable in bit 4; a rising hold latches the buttons and moves up to
// -128..127 of each motion accumulator into the held bytes), a button change, a
// motion delta (saturating 16-bit accumulators) or a timer tick (toggles the request
// and refreshes irq_out). Every item gives exactly one result: read_data (zero for
// non-reads) and irq_out. Throughput is one item per clock while out_bus.ready stays
// high; an accepted item passes the input register and then the result register
// before out_bus.valid rises.
// All state updates happen in the single cycle an item moves from the input register
// into the result register, so back-to-back items see each other's effects in order.
// in_bus.ready stays high while the result register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

module bus_mouse_port_interface (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bmpi_in_if.sink     in_bus,
  bmpi_out_if.source  out_bus
);

  bmpi_pkg::item_t   item_r;
  logic              item_vld_r;
  bmpi_pkg::item_t   in_item;
  bmpi_pkg::result_t res;
  bmpi_pkg::result_t res_r;
  logic              out_vld_r;
  logic              adv;      // input register moves into result register
  logic              in_fire;

  assign adv     = item_vld_r && (!out_vld_r || out_bus.ready);
  assign in_fire = in_bus.valid && in_bus.ready;

  assign in_bus.ready = !item_vld_r || adv;

  assign in_item.cmd            = in_bus.cmd;
  assign in_item.port_value     = in_bus.port_value;
  assign in_item.button_index   = in_bus.button_index;
  assign in_item.button_pressed = in_bus.button_pressed;
  assign in_item.move_x         = in_bus.move_x;
  assign in_item.move_y         = in_bus.move_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_fire) begin
      item_vld_r <= 1'b1;
    end else if (adv) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  bmpi_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (item_r),
    .result (res)
  );

  // Result register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.read_data = res_r.read_data;
  assign out_bus.irq_out   = res_r.irq_out;

endmodule

`default_nettype wire

// ===== rtl/core/bmpi_checker.sv =====
// Port-level assertions for the bus mouse port interface, with bind.
`timescale 1ns / 1ps
`default_nettype none

module bmpi_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data,
  input wire logic       out_irq_out
);

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result follows an accepted item through the input and result registers
  a_rise_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching item");

  // nothing blocks the input while the result side is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_irq_out))
    else $error("stalled result changed");

endmodule

bind bus_mouse_port_interface bmpi_checker u_bmpi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_irq_out   (out_bus.irq_out)
);

`default_nettype wire

// ===== verif/tb_bus_mouse_port_interface.sv =====
// Testbench for the bus mouse port interface: directed port accesses, then random mouse traffic.
`timescale 1ns / 1ps

module tb_bus_mouse_port_interface;

  // Command seven has no name in the package; the block must treat it as a no-op.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Nibble selector values for port A reads.
  localparam logic [1:0] NIB_X_LO = 2'd0;
  localparam logic [1:0] NIB_X_HI = 2'd1;
  localparam logic [1:0] NIB_Y_LO = 2'd2;
  localparam logic [1:0] NIB_Y_HI = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES  = 8;     // idle wait after the final drain
  localparam int PHASE_ITEMS    = 330;   // items per random traffic phase

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bmpi_in_if  in_bus ();
  bmpi_out_if out_bus ();

  bus_mouse_port_interface uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Handshake pressure knobs, changed only between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int items_sent   = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  // Results owed by the block, oldest first.
  bmpi_pkg::result_t port_results_due[$];

  // Shadow copy of the mouse state.
  logic signed [15:0] m_pend_x;
  logic signed [15:0] m_pend_y;
  logic [2:0]         m_live_buttons;
  logic [7:0]         m_held_x;
  logic [7:0]         m_held_y;
  logic [2:0]         m_held_buttons;
  logic               m_hold;
  logic [1:0]         m_nib_sel;
  logic               m_irq_en;
  logic               m_irq_req;
  logic               m_irq_lvl;

  initial begin
    m_pend_x       = '0;
    m_pend_y       = '0;
    m_live_buttons = '0;
    m_held_x       = '0;
    m_held_y       = '0;
    m_held_buttons = '0;
    m_hold         = 1'b0;
    m_nib_sel      = NIB_X_LO;
    m_irq_en       = 1'b0;
    m_irq_req      = 1'b0;
    m_irq_lvl      = 1'b0;
  end

  //--------------------------------------------------------------------------
  // Clock
  //--------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // Accumulator add with 16-bit signed saturation.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > int'(bmpi_pkg::ACC_MAX)) return bmpi_pkg::ACC_MAX;
    if (s < int'(bmpi_pkg::ACC_MIN)) return bmpi_pkg::ACC_MIN;
    return 16'(s);
  endfunction

  // Portion of an accumulator that fits in one latched byte.
  function automatic int clamp_take(input logic signed [15:0] acc);
    int t;
    t = int'(acc);
    if (t < int'(bmpi_pkg::TAKE_MIN)) t = int'(bmpi_pkg::TAKE_MIN);
    if (t > int'(bmpi_pkg::TAKE_MAX)) t = int'(bmpi_pkg::TAKE_MAX);
    return t;
  endfunction

  // Applies one item to the shadow state and returns the result it produces.
  function automatic bmpi_pkg::result_t predict_port_result(input bmpi_pkg::item_t it);
    bmpi_pkg::result_t r;
    logic [3:0]        nib;
    int                tx;
    int                ty;
    r.read_data = '0;
    case (it.cmd)
      bmpi_pkg::CMD_READ_A: begin
        case (m_nib_sel)
          NIB_X_LO: nib = m_held_x[3:0];
          NIB_X_HI: nib = m_held_x[7:4];
          NIB_Y_LO: nib = m_held_y[3:0];
          default:  nib = m_held_y[7:4];
        endcase
        // buttons read active low in bits 7:5, bit 4 always zero
        r.read_data = {~m_held_buttons, 1'b0, nib};
      end
      bmpi_pkg::CMD_READ_B: r.read_data = bmpi_pkg::PORT_B_VALUE;
      bmpi_pkg::CMD_READ_C: r.read_data = {7'd0, m_irq_req & m_irq_en};
      bmpi_pkg::CMD_WRITE_C: begin
        // latch only on a rising hold; the remainder stays pending
        if (it.port_value[bmpi_pkg::HOLD_BIT] && !m_hold) begin
          m_held_buttons = m_live_buttons;
          tx = clamp_take(m_pend_x);
          ty = clamp_take(m_pend_y);
          m_pend_x = m_pend_x - 16'(tx);
          m_pend_y = m_pend_y - 16'(ty);
          m_held_x = tx[7:0];
          m_held_y = ty[7:0];
        end
        m_hold    = it.port_value[bmpi_pkg::HOLD_BIT];
        m_nib_sel = it.port_value[bmpi_pkg::NIB_SEL_LO +: 2];
        m_irq_en  = !it.port_value[bmpi_pkg::IRQ_DIS_BIT];
      end
      bmpi_pkg::CMD_BUTTON: begin
        // index three touches nothing
        if (it.button_index < bmpi_pkg::NUM_BUTTONS) begin
          m_live_buttons[it.button_index] = it.button_pressed;
        end
      end
      bmpi_pkg::CMD_MOTION: begin
        m_pend_x = sat_add(m_pend_x, it.move_x);
        m_pend_y = sat_add(m_pend_y, it.move_y);
      end
      bmpi_pkg::CMD_TICK: begin
        // the line level only follows the enable at tick time
        m_irq_req = !m_irq_req;
        m_irq_lvl = m_irq_req & m_irq_en;
      end
      default: ;
    endcase
    r.irq_out = m_irq_lvl;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Item construction and sending
  //--------------------------------------------------------------------------
  function automatic bmpi_pkg::item_t make_item(input logic [2:0] cmd,
                                                input logic [7:0] pv,
                                                input logic [1:0] bidx, input logic bprs,
                                                input logic signed [15:0] mx,
                                                input logic signed [15:0] my);
    bmpi_pkg::item_t it;
    it.cmd            = cmd;
    it.port_value     = pv;
    it.button_index   = bidx;
    it.button_pressed = bprs;
    it.move_x         = mx;
    it.move_y         = my;
    return it;
  endfunction

  // Mostly small deltas so latches leave remainders; some full range and extremes.
  function automatic logic signed [15:0] rand_move();
    case ($urandom_range(3))
      0, 1:    return 16'(int'($urandom_range(600)) - 300);
      2:       return 16'($urandom);
      default: return $urandom_range(1) ? bmpi_pkg::ACC_MAX : bmpi_pkg::ACC_MIN;
    endcase
  endfunction

  // Drives one item and waits for its handshake. Valid is left high after
  // acceptance so back-to-back items need no extra edge.
  task automatic send_item(input bmpi_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.cmd            <= it.cmd;
    in_bus.port_value     <= it.port_value;
    in_bus.button_index   <= it.button_index;
    in_bus.button_pressed <= it.button_pressed;
    in_bus.move_x         <= it.move_x;
    in_bus.move_y         <= it.move_y;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    port_results_due.push_back(predict_port_result(it));
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(make_item(3'($urandom), 8'($urandom), 2'($urandom), 1'($urandom),
                        16'($urandom), 16'($urandom)));
  endtask

  // One report as a driver would fetch it: motion and buttons, drop hold,
  // raise hold to latch, then walk the nibbles and check the interrupt.
  task automatic send_mouse_report();
    repeat ($urandom_range(3)) begin
      send_item(make_item(bmpi_pkg::CMD_MOTION, 8'($urandom), 2'($urandom),
                          1'($urandom), rand_move(), rand_move()));
    end
    repeat ($urandom_range(2)) begin
      send_item(make_item(bmpi_pkg::CMD_BUTTON, 8'($urandom), 2'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom)));
    end
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, {1'b0, 7'($urandom)}, 2'd0, 1'b0,
                        16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, {1'b1, 7'($urandom)}, 2'd0, 1'b0,
                        16'd0, 16'd0));
    repeat ($urandom_range(1, 4)) begin
      // hold stays high, so these only move the selector and the enable
      send_item(make_item(bmpi_pkg::CMD_WRITE_C, {1'b1, 7'($urandom)}, 2'd0, 1'b0,
                          16'd0, 16'd0));
      send_item(make_item(bmpi_pkg::CMD_READ_A, 8'($urandom), 2'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom)));
    end
    if ($urandom_range(1)) begin
      send_item(make_item(bmpi_pkg::CMD_TICK, 8'($urandom), 2'd0, 1'b0, 16'd0, 16'd0));
    end
    send_item(make_item(bmpi_pkg::CMD_READ_C, 8'($urandom), 2'd0, 1'b0, 16'd0, 16'd0));
    if ($urandom_range(3) == 0) begin
      send_item(make_item(bmpi_pkg::CMD_READ_B, 8'($urandom), 2'd0, 1'b0, 16'd0, 16'd0));
    end
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    while (port_results_due.size() != 0) @(posedge clk);
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Reset values, every port, every event, nibble walk, saturation, odd inputs.
  task automatic test_port_basics();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_item(bmpi_pkg::CMD_READ_A, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_B, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_C, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_TICK, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    // both accumulators pinned at opposite ends
    send_item(make_item(bmpi_pkg::CMD_MOTION, 8'h00, 2'd0, 1'b0,
                        bmpi_pkg::ACC_MAX, bmpi_pkg::ACC_MIN));
    send_item(make_item(bmpi_pkg::CMD_MOTION, 8'h00, 2'd0, 1'b0,
                        bmpi_pkg::ACC_MAX, bmpi_pkg::ACC_MIN));
    send_item(make_item(bmpi_pkg::CMD_BUTTON, 8'h00, 2'd0, 1'b1, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_BUTTON, 8'h00, 2'd2, 1'b1, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_BUTTON, 8'hFF, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'h80, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_A, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    // hold already high: selector moves, nothing relatched
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'hA0, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_A, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'hC0, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_A, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'hF0, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_A, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_TICK, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    // enable without tick: status bit follows, line does not
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'h60, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_READ_C, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_TICK, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(bmpi_pkg::CMD_BUTTON, 8'h00, 2'd0, 1'b0, 16'd0, 16'd0));
    send_item(make_item(CMD_UNUSED, 8'hFF, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(make_item(bmpi_pkg::CMD_WRITE_C, 8'h80, 2'd0, 1'b0, 16'd0, 16'd0));
    wait_for_drain();
  endtask

  // Mostly well-formed reports with noise in between, under one pressure setting.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        send_mouse_report();
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end
    wait_for_drain();
  endtask

  // Bursts against a stalling receiver, each followed by a full drain.
  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    repeat (4) begin
      repeat (3) send_mouse_report();
      send_noise();
      wait_for_drain();
    end
  endtask

  //--------------------------------------------------------------------------
  // Receiver: ready stalls at the phase rate
  //--------------------------------------------------------------------------
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  //--------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest owed one
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    bmpi_pkg::result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (port_results_due.size() == 0) begin
        $error("unexpected result: read_data %02h irq_out %0b",
               out_bus.read_data, out_bus.irq_out);
        fail_count++;
      end else begin
        want = port_results_due.pop_front();
        if (out_bus.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %02h, actual %02h",
                 want.read_data, out_bus.read_data);
          fail_count++;
        end
        if (out_bus.irq_out !== want.irq_out) begin
          $error("irq_out mismatch: expected %0b, actual %0b",
                 want.irq_out, out_bus.irq_out);
          fail_count++;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Watchdog: counts cycles with no handshake on either channel
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("bus_mouse_port_interface verification failed");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin
    in_bus.valid          <= 1'b0;
    in_bus.cmd            <= bmpi_pkg::CMD_READ_A;
    in_bus.port_value     <= '0;
    in_bus.button_index   <= '0;
    in_bus.button_pressed <= 1'b0;
    in_bus.move_x         <= '0;
    in_bus.move_y         <= '0;
    // synchronous reset held low, then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_port_basics();
    test_random_traffic(0, 0);
    test_random_traffic(74, 0);
    test_random_traffic(0, 74);
    test_random_traffic(12, 12);
    test_pause_until_drained();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (port_results_due.size() != 0) begin
      $error("%0d results never arrived", port_results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("bus_mouse_port_interface verification clean");
    end else begin
      $display("bus_mouse_port_interface verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bmpi_pkg.sv
rtl/core/bmpi_if.sv
rtl/core/bmpi_core.sv
rtl/core/bus_mouse_port_interface.sv
rtl/core/bmpi_checker.sv
verif/tb_bus_mouse_port_interface.sv
